>>> rtl/h264_nal_unit_splitter_core_assert.svh
// Assertion macros used by the checker
`ifndef H264_NAL_UNIT_SPLITTER_CORE_ASSERT_SVH
`define H264_NAL_UNIT_SPLITTER_CORE_ASSERT_SVH

// same-cycle implication, masked during reset
`define NALSP_ASSERT_IMPL(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define NALSP_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

// next-cycle implication, checked through reset as well
`define NALSP_ASSERT_RAW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) (ant) |=> (cons)) else $error(msg);

`endif

>>> rtl/nalsp_pkg.sv
`default_nettype none

package nalsp_pkg;

  localparam int OFFSET_W       = 32;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 3;
  localparam int PREFIX_CFG_W   = 3;
  localparam int START_CODE_LEN = 3;
  localparam logic [PREFIX_CFG_W-1:0] MAX_PREFIX_BYTES = 3'd4;
  localparam logic [PREFIX_CFG_W-1:0] ANNEXB_MODE      = 3'd0;

  // register index, taken from paddr[2]
  localparam logic REG_LENGTH_PREFIX = 1'b0;

  typedef struct packed {
    logic [OFFSET_W-1:0] unit_offset;
    logic [OFFSET_W-1:0] payload_offset;
    logic [7:0]          header;
  } unit_t;

endpackage

`default_nettype wire

>>> rtl/nalsp_front.sv
`default_nettype none

module nalsp_front #(
  parameter int POSITION_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                restart,
  input  wire logic [nalsp_pkg::PREFIX_CFG_W-1:0]  prefix_cfg,
  input  wire logic                                accept,
  input  wire logic [7:0]                          data_byte,
  input  wire logic                                buffer_end,
  output logic                                     push,
  output nalsp_pkg::unit_t                         push_unit
);

  localparam logic [1:0] PH_SCAN   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_HELD   = 2'd2;

  logic [POSITION_BITS-1:0]           pos_r;
  logic [1:0]                         phase_r, phase_nxt;
  logic [1:0]                         zrun_r, zrun_nxt;
  logic [2:0]                         cnt_r, cnt_nxt;
  logic [7:0]                         hdr_r, hdr_nxt;
  logic [POSITION_BITS-1:0]           start_r, start_nxt;
  logic [31:0]                        acc_r, acc_nxt;
  logic [31:0]                        skip_r, skip_nxt;
  logic [nalsp_pkg::PREFIX_CFG_W-1:0] size;
  logic                               emit;
  logic [POSITION_BITS-1:0]           emit_start;
  logic [POSITION_BITS-1:0]           emit_payload;
  logic [7:0]                         emit_hdr;
  logic                               held;
  logic [31:0]                        acc_base;
  logic [2:0]                         cnt_inc;

  assign size = (prefix_cfg > nalsp_pkg::MAX_PREFIX_BYTES) ?
                nalsp_pkg::MAX_PREFIX_BYTES : prefix_cfg;

  always_comb begin
    phase_nxt    = phase_r;
    zrun_nxt     = zrun_r;
    cnt_nxt      = cnt_r;
    hdr_nxt      = hdr_r;
    start_nxt    = start_r;
    acc_nxt      = acc_r;
    skip_nxt     = skip_r;
    emit         = 1'b0;
    emit_start   = start_r;
    emit_payload = start_r + POSITION_BITS'(nalsp_pkg::START_CODE_LEN);
    emit_hdr     = hdr_r;
    held         = 1'b0;
    acc_base     = '0;
    cnt_inc      = cnt_r + 3'd1;
    if (size == nalsp_pkg::ANNEXB_MODE) begin
      if (phase_r == PH_HELD) begin
        emit      = 1'b1;
        phase_nxt = PH_SCAN;
      end
      if (phase_r == PH_HEADER) begin
        hdr_nxt   = data_byte;
        start_nxt = pos_r - POSITION_BITS'(nalsp_pkg::START_CODE_LEN);
        phase_nxt = PH_HELD;
        zrun_nxt  = {1'b0, data_byte == 8'd0};
      end else if (data_byte == 8'd0) begin
        if (zrun_r != 2'd3) begin
          zrun_nxt = zrun_r + 2'd1;
        end
      end else if (data_byte == 8'd1 && zrun_r >= 2'd2) begin
        phase_nxt = PH_HEADER;
        zrun_nxt  = 2'd0;
      end else begin
        zrun_nxt = 2'd0;
      end
    end else begin
      held = (phase_r == PH_HELD);
      if (phase_r == PH_HEADER) begin
        emit         = 1'b1;
        emit_payload = pos_r;
        emit_hdr     = data_byte;
        held         = 1'b1;
        phase_nxt    = PH_HELD;
      end
      if (held && skip_r != 32'd0) begin
        skip_nxt = skip_r - 32'd1;
        if (skip_r == 32'd1) begin
          phase_nxt = PH_SCAN;
        end
      end else begin
        // length prefix byte
        if (cnt_r == 3'd0) begin
          start_nxt = pos_r;
        end else begin
          acc_base = acc_r;
        end
        acc_nxt = {acc_base[23:0], data_byte};
        if (cnt_inc >= size) begin
          skip_nxt  = {acc_base[23:0], data_byte};
          cnt_nxt   = 3'd0;
          phase_nxt = PH_HEADER;
        end else begin
          cnt_nxt   = cnt_inc;
          phase_nxt = PH_SCAN;
        end
      end
    end
  end

  assign push                     = accept && emit;
  assign push_unit.unit_offset    = nalsp_pkg::OFFSET_W'(emit_start);
  assign push_unit.payload_offset = nalsp_pkg::OFFSET_W'(emit_payload);
  assign push_unit.header         = emit_hdr;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      pos_r   <= '0;
      phase_r <= PH_SCAN;
      zrun_r  <= 2'd0;
      cnt_r   <= 3'd0;
    end else if (accept) begin
      if (buffer_end) begin
        pos_r   <= '0;
        phase_r <= PH_SCAN;
        zrun_r  <= 2'd0;
        cnt_r   <= 3'd0;
      end else begin
        pos_r   <= pos_r + POSITION_BITS'(1);
        phase_r <= phase_nxt;
        zrun_r  <= zrun_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_r   <= hdr_nxt;
      start_r <= start_nxt;
      acc_r   <= acc_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nalsp_queue.sv
`default_nettype none

module nalsp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire nalsp_pkg::unit_t  push_unit,
  output logic                   full,
  output logic                   not_empty,
  input  wire logic              pop,
  output nalsp_pkg::unit_t       pop_unit
);

  nalsp_pkg::unit_t slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_unit  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_unit;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nalsp_back.sv
`default_nettype none

module nalsp_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_not_empty,
  input  wire nalsp_pkg::unit_t                q_unit,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [nalsp_pkg::OFFSET_W-1:0]       out_unit_offset,
  output logic [nalsp_pkg::OFFSET_W-1:0]       out_payload_offset,
  output logic                                 out_forbidden_zero,
  output logic [1:0]                           out_reference_priority,
  output logic [4:0]                           out_unit_kind
);

  logic valid_r;

  assign q_pop     = q_not_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_unit_offset        <= q_unit.unit_offset;
      out_payload_offset     <= q_unit.payload_offset;
      out_forbidden_zero     <= q_unit.header[7];
      out_reference_priority <= q_unit.header[6:5];
      out_unit_kind          <= q_unit.header[4:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/h264_nal_unit_splitter_core.sv
// Path: a unit found by the byte parser goes through the two-item queue, then the output register, to out_*.
// Throughput: one byte per cycle while the queue is not full; the byte parser updates its state on each accepted byte.
// A two-item queue and the output register let input run while a result waits.
// Reset (rst_n low, synchronous): parser back to Annex B search at offset 0,
// length_prefix_bytes cleared, queue and output emptied.
`default_nettype none

module h264_nal_unit_splitter_core #(
  parameter int POSITION_BITS = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [nalsp_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [nalsp_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [nalsp_pkg::CFG_DATA_W-1:0]           prdata,
  output logic                                       pready,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [7:0]                            in_data_byte,
  input  wire logic                                  in_buffer_end,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [nalsp_pkg::OFFSET_W-1:0]             out_unit_offset,
  output logic [nalsp_pkg::OFFSET_W-1:0]             out_payload_offset,
  output logic                                       out_forbidden_zero,
  output logic [1:0]                                 out_reference_priority,
  output logic [4:0]                                 out_unit_kind
);

  logic [nalsp_pkg::PREFIX_CFG_W-1:0] prefix_cfg_r;
  logic                               cfg_wr;
  logic                               accept;
  logic                               push;
  logic                               q_full;
  logic                               q_not_empty;
  logic                               q_pop;
  nalsp_pkg::unit_t                   push_unit;
  nalsp_pkg::unit_t                   q_unit;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == nalsp_pkg::REG_LENGTH_PREFIX);
  assign prdata   = (paddr[2] == nalsp_pkg::REG_LENGTH_PREFIX) ?
                    nalsp_pkg::CFG_DATA_W'(prefix_cfg_r) : '0;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_cfg_r <= nalsp_pkg::ANNEXB_MODE;
    end else if (cfg_wr) begin
      prefix_cfg_r <= pwdata[nalsp_pkg::PREFIX_CFG_W-1:0];
    end
  end

  nalsp_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr),
    .prefix_cfg (prefix_cfg_r),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .buffer_end (in_buffer_end),
    .push       (push),
    .push_unit  (push_unit)
  );

  nalsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_unit (push_unit),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_unit  (q_unit)
  );

  nalsp_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_not_empty            (q_not_empty),
    .q_unit                 (q_unit),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_unit_offset        (out_unit_offset),
    .out_payload_offset     (out_payload_offset),
    .out_forbidden_zero     (out_forbidden_zero),
    .out_reference_priority (out_reference_priority),
    .out_unit_kind          (out_unit_kind)
  );

endmodule

`default_nettype wire

>>> rtl/nalsp_checker.sv
`default_nettype none
`include "h264_nal_unit_splitter_core_assert.svh"

module nalsp_checker #(
  parameter int POSITION_BITS = 32
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              pready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [nalsp_pkg::OFFSET_W-1:0]    out_unit_offset,
  input wire logic [nalsp_pkg::OFFSET_W-1:0]    out_payload_offset
);

  logic [nalsp_pkg::OFFSET_W-1:0] gap;
  logic                           wide_pos;

  assign gap      = out_payload_offset - out_unit_offset;
  assign wide_pos = (POSITION_BITS >= nalsp_pkg::OFFSET_W);

  // header sits 1..4 bytes after the unit start
  `NALSP_ASSERT_IMPL(a_gap, out_valid && wide_pos, gap == 32'd1 || gap == 32'd2 || gap == 32'd3 || gap == 32'd4, "payload offset not 1..4 past unit offset")
  `NALSP_ASSERT_IMPL(a_pready, 1'b1, pready, "pready dropped")
  `NALSP_ASSERT_RAW(a_rst_out, !rst_n, !out_valid, "output valid after reset")
  `NALSP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_unit_offset) && $stable(out_payload_offset), "stalled item changed")

endmodule

bind h264_nal_unit_splitter_core nalsp_checker #(
  .POSITION_BITS (POSITION_BITS)
) u_nalsp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .pready             (pready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_unit_offset    (out_unit_offset),
  .out_payload_offset (out_payload_offset)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_BYTES     = 24;

  localparam logic [nalsp_pkg::CFG_ADDR_W-1:0] ADDR_LENGTH_PREFIX =
    {nalsp_pkg::REG_LENGTH_PREFIX, 2'b00};
  localparam logic [nalsp_pkg::CFG_ADDR_W-1:0] ADDR_SPARE =
    {~nalsp_pkg::REG_LENGTH_PREFIX, 2'b00};

  typedef enum logic [1:0] {PH_SEARCH, PH_HEADER_NEXT, PH_BODY} parse_phase_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  class nal_split_board;
    logic [nalsp_pkg::PREFIX_CFG_W-1:0] prefix_cfg;
    logic [nalsp_pkg::OFFSET_W-1:0]     pos;
    parse_phase_t                       phase;
    logic [1:0]                         zero_run;
    logic [7:0]                         held_hdr;
    logic [nalsp_pkg::OFFSET_W-1:0]     held_start;
    logic [31:0]                        len_acc;
    logic [2:0]                         prefix_cnt;
    logic [31:0]                        skip_left;
    nalsp_pkg::unit_t                   expected_units[$];
    int                                 mismatches;
    int                                 units_checked;

    function new();
      prefix_cfg    = nalsp_pkg::ANNEXB_MODE;
      mismatches    = 0;
      units_checked = 0;
      restart();
    endfunction

    function void restart();
      pos        = '0;
      phase      = PH_SEARCH;
      zero_run   = '0;
      held_hdr   = '0;
      held_start = '0;
      len_acc    = '0;
      prefix_cnt = '0;
      skip_left  = '0;
    endfunction

    function void write_reg(logic index, logic [nalsp_pkg::CFG_DATA_W-1:0] value);
      if (index == nalsp_pkg::REG_LENGTH_PREFIX) begin
        prefix_cfg = value[nalsp_pkg::PREFIX_CFG_W-1:0];
        restart();
      end
    endfunction

    function logic [nalsp_pkg::PREFIX_CFG_W-1:0] prefix_size();
      return (prefix_cfg > nalsp_pkg::MAX_PREFIX_BYTES) ?
             nalsp_pkg::MAX_PREFIX_BYTES : prefix_cfg;
    endfunction

    function void track_byte(logic [7:0] b, logic last);
      nalsp_pkg::unit_t                   u;
      bit                                 hit;
      bit                                 consumed;
      logic [nalsp_pkg::PREFIX_CFG_W-1:0] size;
      hit      = 0;
      consumed = 0;
      size     = prefix_size();
      u        = '0;
      if (size == nalsp_pkg::ANNEXB_MODE) begin
        if (phase == PH_BODY) begin
          u.unit_offset    = held_start;
          u.payload_offset = held_start + nalsp_pkg::START_CODE_LEN;
          u.header         = held_hdr;
          hit              = 1;
          phase            = PH_SEARCH;
        end
        if (phase == PH_HEADER_NEXT) begin
          held_hdr   = b;
          held_start = pos - nalsp_pkg::START_CODE_LEN;
          phase      = PH_BODY;
          zero_run   = (b == 8'h00) ? 2'd1 : 2'd0;
        end else if (b == 8'h00) begin
          if (zero_run < 2'd3) zero_run++;
        end else if (b == 8'h01 && zero_run >= 2'd2) begin
          phase    = PH_HEADER_NEXT;
          zero_run = '0;
        end else begin
          zero_run = '0;
        end
      end else begin
        if (phase == PH_HEADER_NEXT) begin
          u.unit_offset    = held_start;
          u.payload_offset = pos;
          u.header         = b;
          hit              = 1;
          phase            = PH_BODY;
        end
        if (phase == PH_BODY) begin
          if (skip_left != 0) begin
            skip_left--;
            if (skip_left == 0) phase = PH_SEARCH;
            consumed = 1;
          end else begin
            phase = PH_SEARCH;
          end
        end
        if (!consumed) begin
          if (prefix_cnt == 0) begin
            held_start = pos;
            len_acc    = '0;
          end
          len_acc = {len_acc[23:0], b};
          prefix_cnt++;
          if (prefix_cnt >= size) begin
            skip_left  = len_acc;
            prefix_cnt = '0;
            phase      = PH_HEADER_NEXT;
          end
        end
      end
      pos++;
      if (last) restart();
      if (hit) expected_units.push_back(u);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [nalsp_pkg::OFFSET_W-1:0] unit_off,
                      logic [nalsp_pkg::OFFSET_W-1:0] payload_off,
                      logic fz, logic [1:0] ref_pri, logic [4:0] kind);
      nalsp_pkg::unit_t e;
      if (expected_units.size() == 0) begin
        report($sformatf("unit at offset %0d with none expected", unit_off));
        return;
      end
      e = expected_units.pop_front();
      units_checked++;
      if (unit_off !== e.unit_offset)
        report($sformatf("unit_offset %0d, want %0d", unit_off, e.unit_offset));
      if (payload_off !== e.payload_offset)
        report($sformatf("payload_offset %0d, want %0d", payload_off, e.payload_offset));
      if (fz !== e.header[7])
        report($sformatf("forbidden_zero %b, want %b", fz, e.header[7]));
      if (ref_pri !== e.header[6:5])
        report($sformatf("reference_priority %0d, want %0d", ref_pri, e.header[6:5]));
      if (kind !== e.header[4:0])
        report($sformatf("unit_kind %0d, want %0d", kind, e.header[4:0]));
    endtask
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [nalsp_pkg::CFG_ADDR_W-1:0]   paddr = '0;
  logic [nalsp_pkg::CFG_DATA_W-1:0]   pwdata = '0;
  logic [nalsp_pkg::CFG_DATA_W-1:0]   prdata;
  logic                               pready;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [7:0]                         in_data_byte = '0;
  logic                               in_buffer_end = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [nalsp_pkg::OFFSET_W-1:0]     out_unit_offset;
  logic [nalsp_pkg::OFFSET_W-1:0]     out_payload_offset;
  logic                               out_forbidden_zero;
  logic [1:0]                         out_reference_priority;
  logic [4:0]                         out_unit_kind;

  nal_split_board          board;
  byte_item_t              stim_q[$];
  logic [7:0]              scratch[$];
  idle_mode_t              idle_mode = IDLE_NONE;
  logic                    hold_off = 1'b0;
  int                      bytes_queued = 0;
  int                      bytes_accepted = 0;
  int                      input_stall_cycles = 0;
  int                      quiet_cycles = 0;
  int                      phase_count = 0;

  h264_nal_unit_splitter_core u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_data_byte           (in_data_byte),
    .in_buffer_end          (in_buffer_end),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_unit_offset        (out_unit_offset),
    .out_payload_offset     (out_payload_offset),
    .out_forbidden_zero     (out_forbidden_zero),
    .out_reference_priority (out_reference_priority),
    .out_unit_kind          (out_unit_kind)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit sender_offers();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) >= 67;
      IDLE_BOTH:   return $urandom_range(99) >= 14;
      default:     return 1'b1;
    endcase
  endfunction

  function automatic bit receiver_takes();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) >= 67;
      IDLE_BOTH:     return $urandom_range(99) >= 14;
      default:       return 1'b1;
    endcase
  endfunction

  // zeros and ones weighted up so start codes turn up inside noise
  function automatic logic [7:0] stream_byte();
    int r;
    r = $urandom_range(9);
    if (r < 3) return 8'h00;
    if (r == 3) return 8'h01;
    return 8'($urandom_range(255));
  endfunction

  always @(posedge clk) begin : sender
    byte_item_t nxt;
    if (in_valid && in_ready) begin
      board.track_byte(in_data_byte, in_buffer_end);
      bytes_accepted++;
    end
    if (in_valid && !in_ready) begin
      input_stall_cycles++;
    end else if (rst_n && stim_q.size() != 0 && sender_offers()) begin
      nxt = stim_q.pop_front();
      in_valid      <= 1'b1;
      in_data_byte  <= nxt.data;
      in_buffer_end <= nxt.last;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_ready <= !hold_off && receiver_takes();
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_unit_offset, out_payload_offset, out_forbidden_zero,
                         out_reference_priority, out_unit_kind);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task push_byte(logic [7:0] b, logic last);
    byte_item_t it;
    it.data = b;
    it.last = last;
    stim_q.push_back(it);
    bytes_queued++;
  endtask

  task flush_scratch(bit close);
    foreach (scratch[i]) push_byte(scratch[i], close && (i == scratch.size() - 1));
    scratch.delete();
  endtask

  task trim_scratch();
    int k;
    k = $urandom_range(3, 1);
    while (k > 0 && scratch.size() > 1) begin
      void'(scratch.pop_back());
      k--;
    end
  endtask

  task gen_annexb_buffer();
    scratch.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(16, 4)) scratch.push_back(stream_byte());
    end else begin
      repeat ($urandom_range(3)) scratch.push_back(8'($urandom_range(255)));
      repeat ($urandom_range(4, 1)) begin
        if ($urandom_range(3) == 0) scratch.push_back(8'h00);
        scratch.push_back(8'h00);
        scratch.push_back(8'h00);
        scratch.push_back(8'h01);
        scratch.push_back(8'($urandom_range(255)));
        repeat ($urandom_range(6, 1)) scratch.push_back(stream_byte());
      end
      if ($urandom_range(6) == 0) trim_scratch();
    end
    flush_scratch(1);
  endtask

  task gen_prefixed_buffer(logic [nalsp_pkg::PREFIX_CFG_W-1:0] size);
    logic [31:0] len;
    logic [31:0] mask;
    int          units;
    int          u;
    int          r;
    bit          big;
    mask = (size == nalsp_pkg::MAX_PREFIX_BYTES) ? 32'hFFFF_FFFF :
           ((32'd1 << (8 * int'(size))) - 1);
    scratch.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(12, 3)) scratch.push_back(stream_byte());
    end else begin
      units = $urandom_range(4, 1);
      big   = 0;
      u     = 0;
      while (u < units && !big) begin
        r = $urandom_range(99);
        if (r < 8) begin
          len = '0;
        end else if (r < 16) begin
          len = $urandom() & mask;
          big = 1;
        end else begin
          len = $urandom_range(6, 1);
        end
        for (int i = int'(size) - 1; i >= 0; i--) scratch.push_back(len[8*i +: 8]);
        if (big) begin
          // random length, mostly past the buffer: one to five bytes, then the buffer ends
          repeat ($urandom_range(5, 1)) scratch.push_back(8'($urandom_range(255)));
        end else if (len != 0) begin
          repeat (len) scratch.push_back(8'($urandom_range(255)));
        end else if (u == units - 1) begin
          scratch.push_back(8'($urandom_range(255)));
        end
        u++;
      end
      if ($urandom_range(6) == 0) trim_scratch();
    end
    flush_scratch(1);
  endtask

  task gen_phase(int n_bytes);
    int                                 target;
    logic [nalsp_pkg::PREFIX_CFG_W-1:0] size;
    target = bytes_queued + n_bytes;
    size   = board.prefix_size();
    while (bytes_queued < target) begin
      if (size == nalsp_pkg::ANNEXB_MODE) gen_annexb_buffer();
      else gen_prefixed_buffer(size);
    end
    // sometimes leave a buffer open so the next register write cuts it off
    if ($urandom_range(1)) begin
      repeat ($urandom_range(5, 1)) scratch.push_back(stream_byte());
      flush_scratch(0);
    end
    phase_count++;
  endtask

  task wait_idle();
    while (bytes_accepted != bytes_queued) @(posedge clk);
    while (board.expected_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task cfg_write(logic [nalsp_pkg::CFG_ADDR_W-1:0] addr,
                 logic [nalsp_pkg::PREFIX_CFG_W-1:0] value);
    logic [nalsp_pkg::CFG_DATA_W-1:0] w;
    w = $urandom();
    w[nalsp_pkg::PREFIX_CFG_W-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= w;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.write_reg(addr[2], w);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task run_pressure();
    idle_mode = IDLE_NONE;
    cfg_write(ADDR_LENGTH_PREFIX, nalsp_pkg::ANNEXB_MODE);
    fork
      begin
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (16) begin
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'($urandom_range(255)), 1'b0);
    end
    push_byte(8'($urandom_range(255)), 1'b1);
    phase_count++;
    wait_idle();
  endtask

  logic [nalsp_pkg::PREFIX_CFG_W-1:0] cfg_plan  [10] = '{3'd0, 3'd2, 3'd4, 3'd3, 3'd1,
                                                         3'd7, 3'd0, 3'd5, 3'd6, 3'd4};
  idle_mode_t                         mode_plan [10] = '{IDLE_SENDER, IDLE_RECEIVER,
                                                         IDLE_BOTH, IDLE_NONE,
                                                         IDLE_SENDER, IDLE_RECEIVER,
                                                         IDLE_BOTH, IDLE_NONE,
                                                         IDLE_RECEIVER, IDLE_BOTH};

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Annex B from reset: garbage, four-byte start code, all-ones header,
    // a start code overlapping the previous header, header as last byte,
    // header missing at buffer end
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h65, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h67, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b1);
    phase_count++;
    wait_idle();

    // one-byte prefix: zero-length unit whose header opens the next prefix,
    // then a header as the last byte
    cfg_write(ADDR_LENGTH_PREFIX, 3'd1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h09, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b1);
    phase_count++;
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      idle_mode = mode_plan[p];
      cfg_write(ADDR_LENGTH_PREFIX, cfg_plan[p]);
      gen_phase(PHASE_BYTES);
      wait_idle();
      if (p == 3) begin
        // write to an unmapped address must neither change mode nor restart
        cfg_write(ADDR_SPARE, 3'($urandom_range(7)));
        idle_mode = IDLE_BOTH;
        gen_phase(PHASE_BYTES);
        wait_idle();
      end
      if (p == 4) run_pressure();
    end

    idle_mode = IDLE_NONE;
    $display("Summary: %0d bytes in %0d phases, Annex B and prefix settings 1 to 7, %0d units",
             bytes_accepted, phase_count, board.units_checked);
    $display("Summary: %0d input stall cycles, %0d mismatches",
             input_stall_cycles, board.mismatches);
    if (board.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
